### rtl/cct_pkg.sv
// ----------------------------------------------------------------------------
// cct_pkg: shared types and constants of the character class tokenizer
// Holds the beat structs of both channels, the queue entry, the token kind
// codes and the byte classification functions.
// ----------------------------------------------------------------------------
package cct_pkg;

  // Token kind codes.
  localparam logic [4:0] KIND_IDENT  = 5'd0;
  localparam logic [4:0] KIND_NUMBER = 5'd1;
  localparam logic [4:0] KIND_EOF    = 5'd22;

  // Whitespace bytes.
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_VT    = 8'd11;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_FF    = 8'd12;

  // Run state of the front part.
  typedef enum logic [2:0] {
    MODE_OUTSIDE = 3'b001,
    MODE_IDENT   = 3'b010,
    MODE_NUMBER  = 3'b100
  } run_mode_e;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_text;
  } cct_in_t;

  typedef struct packed {
    logic [4:0] token_kind;
    logic [7:0] out_char;
    logic       out_char_valid;
    logic       token_start;
    logic       token_end;
    logic       last;
  } cct_out_t;

  // One classified input byte: an optional run-closing beat followed by an
  // optional character or end-of-file beat.
  typedef struct packed {
    logic       close_en;
    logic [4:0] close_kind;
    logic       main_en;
    logic [4:0] main_kind;
    logic [7:0] main_char;
    logic       main_char_valid;
    logic       main_start;
    logic       main_end;
  } cct_cmd_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
           c == CH_CR || c == CH_FF;
  endfunction

  // Punctuation kinds follow the order = + * - ; : ( ) { } [ ] < > ! . ' \ / %.
  // Any other byte is a one-character identifier.
  function automatic logic [4:0] punct_kind(input logic [7:0] c);
    logic [4:0] k;
    unique case (c)
      8'h3D:   k = 5'd2;
      8'h2B:   k = 5'd3;
      8'h2A:   k = 5'd4;
      8'h2D:   k = 5'd5;
      8'h3B:   k = 5'd6;
      8'h3A:   k = 5'd7;
      8'h28:   k = 5'd8;
      8'h29:   k = 5'd9;
      8'h7B:   k = 5'd10;
      8'h7D:   k = 5'd11;
      8'h5B:   k = 5'd12;
      8'h5D:   k = 5'd13;
      8'h3C:   k = 5'd14;
      8'h3E:   k = 5'd15;
      8'h21:   k = 5'd16;
      8'h2E:   k = 5'd17;
      8'h27:   k = 5'd18;
      8'h5C:   k = 5'd19;
      8'h2F:   k = 5'd20;
      8'h25:   k = 5'd21;
      default: k = KIND_IDENT;
    endcase
    return k;
  endfunction

endpackage

### rtl/cct_front.sv
// ----------------------------------------------------------------------------
// cct_front: input acceptance and byte classification
// Tracks the run; queues each accepted byte except whitespace outside a run.
// ----------------------------------------------------------------------------
module cct_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  cct_pkg::cct_in_t in_data_i,
  input  logic            q_full_i,
  output logic            q_push_o,
  output cct_pkg::cct_cmd_t q_cmd_o
);
  import cct_pkg::*;

  run_mode_e mode_q, mode_d;
  logic      accept;
  logic      eot;
  logic [7:0] c;
  logic      letter, digit, space;
  logic      stays;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign eot        = in_data_i.end_of_text;
  assign c          = in_data_i.char_byte;
  assign letter     = is_letter(c);
  assign digit      = is_digit(c);
  assign space      = is_space(c);

  always_comb begin
    q_cmd_o = '0;
    mode_d  = mode_q;
    stays   = 1'b0;

    unique case (mode_q)
      MODE_IDENT: begin
        if (!eot && letter) begin
          stays = 1'b1;
        end else begin
          q_cmd_o.close_en   = 1'b1;
          q_cmd_o.close_kind = KIND_IDENT;
        end
      end
      MODE_NUMBER: begin
        if (!eot && (letter || digit)) begin
          stays = 1'b1;
        end else begin
          q_cmd_o.close_en   = 1'b1;
          q_cmd_o.close_kind = KIND_NUMBER;
        end
      end
      default: ;
    endcase

    if (stays) begin
      q_cmd_o.main_en         = 1'b1;
      q_cmd_o.main_kind       = (mode_q == MODE_NUMBER) ? KIND_NUMBER : KIND_IDENT;
      q_cmd_o.main_char       = c;
      q_cmd_o.main_char_valid = 1'b1;
    end else begin
      mode_d = MODE_OUTSIDE;
      priority if (eot) begin
        q_cmd_o.main_en    = 1'b1;
        q_cmd_o.main_kind  = KIND_EOF;
        q_cmd_o.main_start = 1'b1;
        q_cmd_o.main_end   = 1'b1;
      end else if (space) begin
        q_cmd_o.main_en = 1'b0;
      end else if (letter) begin
        mode_d                  = MODE_IDENT;
        q_cmd_o.main_en         = 1'b1;
        q_cmd_o.main_kind       = KIND_IDENT;
        q_cmd_o.main_char       = c;
        q_cmd_o.main_char_valid = 1'b1;
        q_cmd_o.main_start      = 1'b1;
      end else if (digit) begin
        mode_d                  = MODE_NUMBER;
        q_cmd_o.main_en         = 1'b1;
        q_cmd_o.main_kind       = KIND_NUMBER;
        q_cmd_o.main_char       = c;
        q_cmd_o.main_char_valid = 1'b1;
        q_cmd_o.main_start      = 1'b1;
      end else begin
        q_cmd_o.main_en         = 1'b1;
        q_cmd_o.main_kind       = punct_kind(c);
        q_cmd_o.main_char       = c;
        q_cmd_o.main_char_valid = 1'b1;
        q_cmd_o.main_start      = 1'b1;
        q_cmd_o.main_end        = 1'b1;
      end
    end
  end

  // Whitespace outside a run leaves nothing to do downstream.
  assign q_push_o = accept && (q_cmd_o.close_en || q_cmd_o.main_en);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_OUTSIDE;
    end else if (accept) begin
      mode_q <= mode_d;
    end
  end

endmodule

### rtl/cct_queue.sv
// ----------------------------------------------------------------------------
// cct_queue: short command queue between front and back parts
// Register-based circular buffer with a fill count.
// ----------------------------------------------------------------------------
module cct_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cct_pkg::cct_cmd_t push_cmd_i,
  input  logic              pop_i,
  output cct_pkg::cct_cmd_t head_cmd_o,
  output logic              full_o,
  output logic              empty_o
);
  import cct_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cct_cmd_t        mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   count_q;

  assign full_o     = (count_q == CW'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign head_cmd_o = mem_q[rd_ptr_q];

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH)) else $error("queue fill count out of range");

endmodule

### rtl/cct_back.sv
// ----------------------------------------------------------------------------
// cct_back: result sequencing and output register
// Expands each queue entry into one or two output beats.
// ----------------------------------------------------------------------------
module cct_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cct_pkg::cct_cmd_t head_cmd_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cct_pkg::cct_out_t out_data_o
);
  import cct_pkg::*;

  logic     out_valid_q, out_valid_d;
  cct_out_t out_data_q, out_data_d;
  logic     close_done_q, close_done_d;
  logic     load;

  // The output register takes a new beat when it is empty or being drained.
  assign load = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    close_done_d = close_done_q;
    pop_o        = 1'b0;
    if (load) begin
      out_valid_d = !empty_i;
      if (!empty_i) begin
        if (head_cmd_i.close_en && !close_done_q) begin
          out_data_d.token_kind     = head_cmd_i.close_kind;
          out_data_d.out_char       = '0;
          out_data_d.out_char_valid = 1'b0;
          out_data_d.token_start    = 1'b0;
          out_data_d.token_end      = 1'b1;
          out_data_d.last           = !head_cmd_i.main_en;
          close_done_d              = head_cmd_i.main_en;
          pop_o                     = !head_cmd_i.main_en;
        end else begin
          out_data_d.token_kind     = head_cmd_i.main_kind;
          out_data_d.out_char       = head_cmd_i.main_char;
          out_data_d.out_char_valid = head_cmd_i.main_char_valid;
          out_data_d.token_start    = head_cmd_i.main_start;
          out_data_d.token_end      = head_cmd_i.main_end;
          out_data_d.last           = 1'b1;
          close_done_d              = 1'b0;
          pop_o                     = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      close_done_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      close_done_q <= close_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A half-done entry stays at the head of the queue until its second beat.
  a_split_holds_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    close_done_q |-> !empty_i && head_cmd_i.close_en && head_cmd_i.main_en)
    else $error("split entry lost from queue head");

  // A beat that is not the last of its byte can only be a run-closing beat.
  a_first_is_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_data_q.last) |->
      (out_data_q.token_end && !out_data_q.out_char_valid))
    else $error("non-final beat is not a run close");

endmodule

### rtl/char_class_tokenizer_top.sv
// ----------------------------------------------------------------------------
// char_class_tokenizer_top: byte-serial lexical tokenizer
// Classifies source text bytes into identifier, number, punctuation and
// end-of-file tokens, emitted as a stream of annotated character beats.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid_i, in_stall_o, in_data_i) carries one
// source byte per beat, or an end-of-text mark. The output channel
// (out_valid_o, out_stall_i, out_data_o) carries annotated character beats
// with token start and end marks; the beat flagged last is the final one
// caused by its input byte.
// Each input byte yields zero, one or two output beats. Whitespace outside a
// run yields none; a byte that ends a run first yields a character-less
// closing beat. The front part accepts one byte per cycle while the command
// queue has room; the back part drains one output beat per cycle while the
// receiver does not stall, so a byte that closes a run and starts a new token
// occupies the output for two beats. With the queue empty, the first beat of a
// byte goes from the queue entry written at acceptance into the output
// register, from which it can be taken.
// Reset returns the tokenizer to the outside-of-run state and empties the
// queue and output register. When the receiver stalls, the output beat
// holds, the queue fills, and after QUEUE_DEPTH entries in_stall_o rises.
// ----------------------------------------------------------------------------
module char_class_tokenizer_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cct_pkg::cct_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cct_pkg::cct_out_t out_data_o
);
  import cct_pkg::*;

  // Queue traffic between front and back parts.
  logic     q_push, q_pop, q_full, q_empty;
  cct_cmd_t q_push_cmd, q_head_cmd;

  // Front part: takes bytes, tracks the current run, builds queue entries.
  cct_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (q_push_cmd)
  );

  // Queue: decouples input acceptance from output back-pressure.
  cct_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_push_cmd),
    .pop_i      (q_pop),
    .head_cmd_o (q_head_cmd),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  // Back part: expands each entry into its output beats.
  cct_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_cmd_i  (q_head_cmd),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### tb/char_class_tokenizer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_class_tokenizer_top_tb: self-checking bench for the byte tokenizer
// Feeds directed and random source text, with end-of-text marks, through the
// tokenizer under random idling on both channels and one or more long output
// holds, predicts every annotated output beat, and checks it field by field.
// ----------------------------------------------------------------------------
module char_class_tokenizer_top_tb;
  import cct_pkg::*;

  // Punctuation kinds start right after the number kind, in the order of
  // this table, read from its most significant byte.
  localparam logic [4:0] KIND_PUNCT_BASE = 5'd2;
  localparam int unsigned PUNCT_COUNT = 20;
  localparam logic [8*PUNCT_COUNT-1:0] PUNCT_SET = {"=+*-;:(){}[]<>!.'", 8'h5C, "/%"};

  localparam int unsigned RANDOM_ITEMS = 1900;
  // A byte's first beat passes through the queue and then the output register;
  // the queue is four deep. This margin covers both.
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned HOLD_CYCLES = 96;
  localparam int unsigned HOLD_FIRST = 300;
  localparam int unsigned HOLD_EVERY = 700;
  localparam int unsigned PRINT_LIMIT = 40;

  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_WORD,
    SCAN_NUM
  } scan_state_e;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  cct_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  cct_out_t out_data;

  // Source bytes waiting to be offered, and the beats the tokenizer owes us.
  cct_in_t  source_bytes_q[$];
  cct_out_t token_beats_q[$];

  // Predictor state: which kind of run the text is currently inside.
  scan_state_e scan_state = SCAN_IDLE;

  int unsigned mismatches = 0;
  int unsigned beats_seen = 0;
  int unsigned bytes_taken = 0;

  // Sender idling.
  int unsigned send_gap = 0;
  int unsigned send_quiet = 0;
  // Receiver idling and the long hold that forces the block to back up.
  int unsigned stall_left = 0;
  int unsigned free_left = 0;
  int unsigned hold_left = 0;
  int unsigned next_hold_at = HOLD_FIRST;

  char_class_tokenizer_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  // 12 ns clock, low half first.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Reset is held at the start and never asserted again.
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // ------------------------------------------------------------------------
  // Byte classes. A letter folds to upper case by clearing bit 5; only the
  // two alphabet ranges land in A..Z that way.
  // ------------------------------------------------------------------------
  function automatic logic letter_byte(input logic [7:0] c);
    logic [7:0] folded;
    folded = c & 8'hDF;
    return folded >= "A" && folded <= "Z";
  endfunction

  function automatic logic digit_byte(input logic [7:0] c);
    return c[7:4] == 4'h3 && c[3:0] <= 4'd9;
  endfunction

  function automatic logic blank_byte(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
           c == CH_CR || c == CH_FF;
  endfunction

  function automatic logic [7:0] punct_at(input int unsigned idx);
    return PUNCT_SET[8*(PUNCT_COUNT-1-idx) +: 8];
  endfunction

  // Position in the punctuation table, or -1 for a byte that is not listed.
  function automatic int punct_index(input logic [7:0] c);
    for (int i = 0; i < PUNCT_COUNT; i++) begin
      if (punct_at(i) == c) return i;
    end
    return -1;
  endfunction

  function automatic cct_out_t make_beat(input logic [4:0] kind, input logic [7:0] ch,
                                         input logic has_ch, input logic first,
                                         input logic closing);
    cct_out_t b;
    b.token_kind     = kind;
    b.out_char       = has_ch ? ch : 8'h00;
    b.out_char_valid = has_ch;
    b.token_start    = first;
    b.token_end      = closing;
    b.last           = 1'b0;
    return b;
  endfunction

  // ------------------------------------------------------------------------
  // Predictor. One accepted byte gives at most a run-closing beat followed by
  // a character or end-of-file beat; whichever comes last carries the last
  // flag. A byte that continues the current run gives one plain beat.
  // ------------------------------------------------------------------------
  function automatic void tokenize_byte(input cct_in_t item);
    cct_out_t close_beat;
    cct_out_t main_beat;
    logic     has_close;
    logic     has_main;
    logic     eot;
    logic [7:0] c;
    int       p;

    eot       = item.end_of_text;
    c         = item.char_byte;
    has_close = 1'b0;
    has_main  = 1'b0;
    close_beat = '0;
    main_beat  = '0;

    if (scan_state == SCAN_WORD && !eot && letter_byte(c)) begin
      has_main  = 1'b1;
      main_beat = make_beat(KIND_IDENT, c, 1'b1, 1'b0, 1'b0);
    end else if (scan_state == SCAN_NUM && !eot && (letter_byte(c) || digit_byte(c))) begin
      has_main  = 1'b1;
      main_beat = make_beat(KIND_NUMBER, c, 1'b1, 1'b0, 1'b0);
    end else begin
      // Anything that does not extend the open run closes it first, with a
      // beat that carries no character.
      if (scan_state != SCAN_IDLE) begin
        has_close  = 1'b1;
        close_beat = make_beat(scan_state == SCAN_WORD ? KIND_IDENT : KIND_NUMBER,
                               8'h00, 1'b0, 1'b0, 1'b1);
      end
      scan_state = SCAN_IDLE;

      if (eot) begin
        has_main  = 1'b1;
        main_beat = make_beat(KIND_EOF, 8'h00, 1'b0, 1'b1, 1'b1);
      end else if (blank_byte(c)) begin
        // Whitespace between tokens produces nothing.
      end else if (letter_byte(c)) begin
        scan_state = SCAN_WORD;
        has_main   = 1'b1;
        main_beat  = make_beat(KIND_IDENT, c, 1'b1, 1'b1, 1'b0);
      end else if (digit_byte(c)) begin
        scan_state = SCAN_NUM;
        has_main   = 1'b1;
        main_beat  = make_beat(KIND_NUMBER, c, 1'b1, 1'b1, 1'b0);
      end else begin
        // Listed punctuation gets its own kind; every other byte, including
        // zero and the upper half, is a one-character identifier.
        p         = punct_index(c);
        has_main  = 1'b1;
        main_beat = make_beat(p < 0 ? KIND_IDENT : KIND_PUNCT_BASE + 5'(p),
                              c, 1'b1, 1'b1, 1'b1);
      end
    end

    if (has_main) main_beat.last = 1'b1;
    else close_beat.last = 1'b1;
    if (has_close) token_beats_q.push_back(close_beat);
    if (has_main) token_beats_q.push_back(main_beat);
  endfunction

  // ------------------------------------------------------------------------
  // Stimulus helpers.
  // ------------------------------------------------------------------------
  task automatic add_byte(input logic [7:0] c);
    cct_in_t item;
    item.char_byte   = c;
    item.end_of_text = 1'b0;
    source_bytes_q.push_back(item);
  endtask

  // The byte that rides along with an end-of-text mark is ignored by the
  // block, so callers vary it to show that it really is.
  task automatic add_end_of_text(input logic [7:0] junk);
    cct_in_t item;
    item.char_byte   = junk;
    item.end_of_text = 1'b1;
    source_bytes_q.push_back(item);
  endtask

  function automatic logic [7:0] any_letter();
    return $urandom_range(0, 1) ? 8'(8'h41 + $urandom_range(0, 25))
                                : 8'(8'h61 + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] any_digit();
    return 8'(8'h30 + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] any_blank();
    case ($urandom_range(0, 5))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_LF;
      3:       return CH_VT;
      4:       return CH_CR;
      default: return CH_FF;
    endcase
  endfunction

  // A byte of no class at all: controls, the upper half, unlisted symbols.
  function automatic logic [7:0] any_stray();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (letter_byte(c) || digit_byte(c) || blank_byte(c) || punct_index(c) >= 0);
    return c;
  endfunction

  // Mostly well-formed lexemes, glued together with or without whitespace,
  // so runs get closed by every kind of byte; the rest is noise.
  task automatic add_random_token();
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(0, 99);
    if (pick < 28) begin
      len = $urandom_range(1, 8);
      repeat (len) add_byte(any_letter());
    end else if (pick < 46) begin
      add_byte(any_digit());
      len = $urandom_range(0, 6);
      repeat (len) add_byte($urandom_range(0, 2) == 0 ? any_letter() : any_digit());
    end else if (pick < 66) begin
      add_byte(punct_at($urandom_range(0, PUNCT_COUNT - 1)));
    end else if (pick < 82) begin
      len = $urandom_range(1, 3);
      repeat (len) add_byte(any_blank());
    end else if (pick < 89) begin
      add_byte(any_stray());
    end else if (pick < 95) begin
      add_byte(8'($urandom_range(0, 255)));
    end else begin
      add_end_of_text(8'($urandom_range(0, 255)));
    end
  endtask

  // Idle length for either side: usually none, often short, now and then
  // a long stretch.
  function automatic int unsigned pause_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // ------------------------------------------------------------------------
  // Driver. A new beat is put on the input only when the channel is free,
  // that is when nothing is offered or the offered beat is taken at this
  // edge, so a stalled beat never changes and valid never looks at stall.
  // Each beat is predicted at the edge where it is accepted.
  // ------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        tokenize_byte(in_data);
        bytes_taken <= bytes_taken + 1;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (source_bytes_q.size() != 0) begin
          in_data  <= source_bytes_q.pop_front();
          in_valid <= 1'b1;
          // Pick the gap that follows this beat; a quiet stretch sends
          // back to back.
          if (send_quiet != 0) begin
            send_quiet--;
            send_gap = 0;
          end else begin
            send_gap = pause_len();
            if ($urandom_range(0, 19) == 0) send_quiet = $urandom_range(20, 60);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // Long hold. After a few hundred accepted bytes the receiver refuses all
  // beats for a long stretch while the driver keeps offering, so the
  // internal queue fills and the input stall has to rise.
  // ------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left    <= 0;
      next_hold_at <= HOLD_FIRST;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (bytes_taken >= next_hold_at) begin
      hold_left    <= HOLD_CYCLES;
      next_hold_at <= next_hold_at + HOLD_EVERY;
    end
  end

  // Receiver stall: alternating random stall and free stretches, with the
  // long hold laid on top.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left != 0) begin
        stall_left--;
      end else if (free_left != 0) begin
        free_left--;
      end else begin
        stall_left = pause_len();
        free_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                 : $urandom_range(0, 4);
      end
      out_stall <= (hold_left != 0) || (stall_left != 0);
    end
  end

  // ------------------------------------------------------------------------
  // Monitor. Every beat taken from the output must match the oldest beat
  // still owed, in every field.
  // ------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("%0t ns: output beat %0d: %s", $time, beats_seen, what);
  endtask

  always @(posedge clk_i) begin : monitor
    cct_out_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (token_beats_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat kind %0d char %h",
                                  out_data.token_kind, out_data.out_char));
      end else begin
        want = token_beats_q.pop_front();
        if (out_data.token_kind !== want.token_kind)
          report_mismatch($sformatf("token_kind %0d, expected %0d",
                                    out_data.token_kind, want.token_kind));
        if (out_data.out_char !== want.out_char)
          report_mismatch($sformatf("out_char %h, expected %h",
                                    out_data.out_char, want.out_char));
        if (out_data.out_char_valid !== want.out_char_valid)
          report_mismatch($sformatf("out_char_valid %b, expected %b",
                                    out_data.out_char_valid, want.out_char_valid));
        if (out_data.token_start !== want.token_start)
          report_mismatch($sformatf("token_start %b, expected %b",
                                    out_data.token_start, want.token_start));
        if (out_data.token_end !== want.token_end)
          report_mismatch($sformatf("token_end %b, expected %b",
                                    out_data.token_end, want.token_end));
        if (out_data.last !== want.last)
          report_mismatch($sformatf("last %b, expected %b", out_data.last, want.last));
      end
      beats_seen++;
    end
  end

  // ------------------------------------------------------------------------
  // Stimulus and end of run.
  // ------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned directed_count;

    // Directed text. An identifier "Az" closed by a digit, which opens a
    // number that takes a letter and a digit and is closed by whitespace.
    add_byte("A");
    add_byte("z");
    add_byte("9");
    add_byte("a");
    add_byte("0");
    add_byte(CH_SPACE);
    add_byte(CH_TAB);
    // End of text closing an identifier, then end of text outside any run.
    add_byte("Z");
    add_end_of_text(8'h00);
    add_end_of_text(8'hFF);
    // Byte extremes and the upper half: one-character identifiers.
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(8'h80);
    add_byte(8'h7F);
    // First and last punctuation kinds, and the backslash.
    add_byte(punct_at(0));
    add_byte(punct_at(PUNCT_COUNT - 1));
    add_byte(8'h5C);
    // Identifier closed by punctuation, number closed by end of text.
    add_byte("q");
    add_byte("(");
    add_byte("5");
    add_end_of_text(8'hA5);
    // Remaining whitespace bytes.
    add_byte(CH_LF);
    add_byte(CH_VT);
    add_byte(CH_FF);
    add_byte(CH_CR);
    directed_count = source_bytes_q.size();

    while (source_bytes_q.size() < directed_count + RANDOM_ITEMS) add_random_token();

    // Wait until every byte has gone in and every owed beat has come out,
    // then give the block time to show any beat it should not produce.
    do begin
      @(posedge clk_i);
    end while (source_bytes_q.size() != 0 || in_valid || token_beats_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("char_class_tokenizer_top_tb: PASS");
    end else begin
      $display("char_class_tokenizer_top_tb: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run (every byte with two beats,
  // every beat waiting out the longest stall, every gap at its longest).
  initial begin
    #20_000_000;
    $display("char_class_tokenizer_top_tb: FAIL");
    $finish;
  end

endmodule

### char_class_tokenizer_top.f
rtl/cct_pkg.sv
rtl/cct_front.sv
rtl/cct_queue.sv
rtl/cct_back.sv
rtl/char_class_tokenizer_top.sv
tb/char_class_tokenizer_top_tb.sv
